FILE: rtl/apq_pkg.sv
// Package for the array priority queue: sizes, codes and shared types.
// No dependencies; every other file except apq_ram imports it.
package apq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 4;

    typedef enum logic
    {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic             load;
        logic [IDX_W-1:0] idx;
    } best_ctrl_t;

endpackage

FILE: rtl/apq_if.sv
// Request and response channel interfaces of the array priority queue.
// Depends on apq_pkg.
interface apq_req_if import apq_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    mode_t                    mode;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;

    modport source (output valid, output mode, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input mode, input item_value, input item_priority,
                    output ready);
endinterface

interface apq_rsp_if import apq_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output out_value, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    input occupancy, output ready);
endinterface

FILE: rtl/apq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/apq_best.sv
// Running best-entry tracker with the shared signed priority comparator.
// Depends on apq_pkg.
module apq_best import apq_pkg::*;
(
    input  logic             clk,
    input  best_ctrl_t       ctrl,
    input  entry_t           entry,
    output logic [IDX_W-1:0] best_idx,
    output entry_t           best_entry
);

    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    entry_t           best_entry_reg;
    entry_t           best_entry_next;
    logic             take;

    // first entry always loads; later ones only on strictly greater priority
    assign take = ctrl.load && ((ctrl.idx == '0) || (entry.pri > best_entry_reg.pri));

    always_comb
    begin
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        if (take)
        begin
            best_idx_next   = ctrl.idx;
            best_entry_next = entry;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
    end

    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

FILE: rtl/array_priority_queue_core.sv
// Array priority queue top level: sequencer, entry RAM, best tracker, response register.
// Depends on apq_pkg, apq_if, apq_ram and apq_best.
//
// Holds up to DEPTH entries in insertion order in one RAM. A request is taken only
// while the sequencer is idle; a finished response waits in its own register, so the
// next request is taken while the previous response is still pending. A dequeue reads
// the held entries one per cycle through the comparator to find the winner, then does
// one read and one write per later entry to close the gap, all through the single RAM
// port pair. Ties go to the oldest entry.
module array_priority_queue_core import apq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    apq_req_if.sink   req,
    apq_rsp_if.source rsp
);

    typedef enum logic [5:0]
    {
        S_IDLE     = 6'b000001,
        S_START    = 6'b000010,
        S_SCAN     = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t                   state_reg,  state_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic [CNT_W-1:0]         scan_reg,   scan_next;
    logic [CNT_W-1:0]         ptr_reg,    ptr_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    mode_t                    mode_reg,   mode_next;
    logic signed [DATA_W-1:0] in_val_reg, in_val_next;
    logic signed [DATA_W-1:0] in_pri_reg, in_pri_next;
    status_t                  res_status_reg, res_status_next;
    entry_t                   res_entry_reg,  res_entry_next;
    logic                     rsp_vld_reg, rsp_vld_next;
    status_t                  rsp_status_reg;
    entry_t                   rsp_entry_reg;
    logic [OCC_W-1:0]         rsp_occ_reg;

    logic             load_rsp;
    logic [CNT_W-1:0] ptr_inc;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    best_ctrl_t       best_ctrl;
    logic [IDX_W-1:0] best_idx;
    entry_t           best_entry;

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    apq_best u_best (
        .clk        (clk),
        .ctrl       (best_ctrl),
        .entry      (rd_data),
        .best_idx   (best_idx),
        .best_entry (best_entry)
    );

    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign best_ctrl = '{load: rd_vld_reg, idx: rd_idx_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        mode_next       = mode_reg;
        in_val_next     = in_val_reg;
        in_pri_next     = in_pri_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        load_rsp        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = '{pri: in_pri_reg, val: in_val_reg};
        rd_en           = 1'b0;
        rd_addr         = scan_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next   = req.mode;
                    in_val_next = req.item_value;
                    in_pri_next = req.item_priority;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                res_entry_next = '0;
                if (mode_reg == MODE_ENQ)
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_INSERTED;
                    end
                    state_next = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = scan_reg[IDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    ptr_next   = CNT_W'(best_idx);
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = ST_REMOVED;
                    res_entry_next  = best_entry;
                    state_next      = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                wr_data    = rd_data;
                ptr_next   = ptr_inc;
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (rsp_vld_reg && rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            scan_reg   <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        mode_reg       <= mode_next;
        in_val_reg     <= in_val_next;
        in_pri_reg     <= in_pri_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        if (load_rsp)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_entry_reg  <= res_entry_reg;
            rsp_occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.out_value    = rsp_entry_reg.val;
    assign rsp.out_priority = rsp_entry_reg.pri;
    assign rsp.occupancy    = rsp_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_REMOVED) |->
        (rsp.out_value == '0 && rsp.out_priority == '0))
        else $error("nonzero payload on non-removal response");

endmodule

FILE: tb/tb_array_priority_queue_core.sv
// Self-checking testbench for array_priority_queue_core: a directed run and random requests,
// with the expected responses predicted from a shadow copy of the queue contents.
// Depends on apq_pkg, apq_req_if, apq_rsp_if and array_priority_queue_core.
module tb_array_priority_queue_core import apq_pkg::*;
    ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_START  = 4000;
    localparam int CALM_STOP   = 9000;
    localparam int IDLE_PCT    = 35;

    typedef struct
    {
        mode_t                    mode;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } req_item_t;

    typedef struct
    {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
        logic [OCC_W-1:0]         occ;
    } rsp_item_t;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   error_count = 0;

    req_item_t pending_req[$];
    rsp_item_t awaited_rsp[$];

    logic signed [DATA_W-1:0] held_value[DEPTH];
    logic signed [DATA_W-1:0] held_prio[DEPTH];
    int                       held_count = 0;

    apq_req_if req_ch();
    apq_rsp_if rsp_ch();

    array_priority_queue_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    wire calm = (cycle_count >= CALM_START) && (cycle_count < CALM_STOP);

    function automatic rsp_item_t serve_request(req_item_t r);
        rsp_item_t e;
        int        best;
        int        i;
        e.status = ST_INSERTED;
        e.value  = '0;
        e.prio   = '0;
        if (r.mode == MODE_ENQ)
        begin
            if (held_count >= DEPTH)
            begin
                e.status = ST_FULL;
            end
            else
            begin
                held_value[held_count] = r.value;
                held_prio[held_count]  = r.prio;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            e.status = ST_EMPTY;
        end
        else
        begin
            best = 0;
            for (i = 1; i < held_count; i++)
            begin
                if (held_prio[i] > held_prio[best])
                begin
                    best = i;
                end
            end
            e.status = ST_REMOVED;
            e.value  = held_value[best];
            e.prio   = held_prio[best];
            for (i = best; i + 1 < held_count; i++)
            begin
                held_value[i] = held_value[i + 1];
                held_prio[i]  = held_prio[i + 1];
            end
            held_count--;
        end
        e.occ = OCC_W'(held_count);
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        req_item_t nxt;
        req_item_t taken;
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.mode          <= MODE_ENQ;
            req_ch.item_value    <= '0;
            req_ch.item_priority <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.mode  = req_ch.mode;
                taken.value = req_ch.item_value;
                taken.prio  = req_ch.item_priority;
                awaited_rsp.push_back(serve_request(taken));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_req.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_req.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.mode          <= nxt.mode;
                    req_ch.item_value    <= nxt.value;
                    req_ch.item_priority <= nxt.prio;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_item_t e;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected response: expected none, actual status %s",
                             $time, rsp_ch.status.name());
                end
                else
                begin
                    e = awaited_rsp.pop_front();
                    if (rsp_ch.status !== e.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %s actual %s",
                                 $time, e.status.name(), rsp_ch.status.name());
                    end
                    if (rsp_ch.out_value !== e.value)
                    begin
                        error_count++;
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, e.value, rsp_ch.out_value);
                    end
                    if (rsp_ch.out_priority !== e.prio)
                    begin
                        error_count++;
                        $display("%0t: out_priority expected %0d actual %0d",
                                 $time, e.prio, rsp_ch.out_priority);
                    end
                    if (rsp_ch.occupancy !== e.occ)
                    begin
                        error_count++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, e.occ, rsp_ch.occupancy);
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic add_req(mode_t m, logic signed [DATA_W-1:0] v,
                           logic signed [DATA_W-1:0] p);
        req_item_t r;
        r.mode  = m;
        r.value = v;
        r.prio  = p;
        pending_req.push_back(r);
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("array_priority_queue_core verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int                       i;
        int                       deq_pct;
        logic signed [DATA_W-1:0] p;
        mode_t                    m;
        rst_n = 1'b0;

        add_req(MODE_DEQ, 32'sh1234_5678, 32'sh7fff_ffff);
        add_req(MODE_ENQ, 32'sh7fff_ffff, 32'sh0000_0000);
        add_req(MODE_ENQ, 32'sh8000_0000, 32'sh8000_0000);
        add_req(MODE_ENQ, 32'sh0000_0000, 32'sh7fff_ffff);
        add_req(MODE_ENQ, -32'sd1,        -32'sd1);
        add_req(MODE_ENQ, 32'sd5,         32'sh7fff_ffff);
        add_req(MODE_ENQ, 32'sd6,         32'sh0000_0000);
        add_req(MODE_ENQ, 32'sh5555_5555, 32'shaaaa_aaaa);
        add_req(MODE_ENQ, 32'shaaaa_aaaa, 32'sh5555_5555);
        add_req(MODE_ENQ, 32'shffff_ffff, 32'sh7fff_ffff);
        for (i = 0; i < 8; i++)
        begin
            add_req(MODE_DEQ, $urandom, $urandom);
        end
        add_req(MODE_DEQ, 32'sh0, 32'sh0);
        for (i = 1; i <= 3; i++)
        begin
            add_req(MODE_ENQ, i, 32'sd7);
        end
        for (i = 0; i < 3; i++)
        begin
            add_req(MODE_DEQ, 32'sh0, 32'sh0);
        end

        deq_pct = 50;
        for (i = 0; i < 1225; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: deq_pct = 20;
                    1: deq_pct = 50;
                    default: deq_pct = 80;
                endcase
            end
            m = ($urandom_range(0, 99) < deq_pct) ? MODE_DEQ : MODE_ENQ;
            case ($urandom_range(0, 3))
                0, 1: p = $urandom;
                2: p = $signed($urandom_range(0, 3)) - 2;
                default: p = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            endcase
            add_req(m, $urandom, p);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_req.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (awaited_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (error_count == 0)
        begin
            $display("array_priority_queue_core verification clean");
        end
        else
        begin
            $display("array_priority_queue_core verification failed");
        end
        $finish;
    end

endmodule
